// ----- rtl/core/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned UnitW  = 16;
   localparam int unsigned CpW    = 21;

   // result queue behind the decode stage
   localparam int unsigned QDepth = 4;
   localparam int unsigned QPtrW  = $clog2(QDepth);
   localparam int unsigned QCntW  = $clog2(QDepth + 1);

   // lead byte classes: mask / match pairs
   localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
   localparam logic [ByteW-1:0] Lead2Match = 8'hC0;
   localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
   localparam logic [ByteW-1:0] Lead3Match = 8'hE0;
   localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
   localparam logic [ByteW-1:0] Lead4Match = 8'hF0;
   localparam logic [ByteW-1:0] ContMask   = 8'hC0;
   localparam logic [ByteW-1:0] ContMatch  = 8'h80;

   localparam logic [CpW-1:0] MinCp2     = 21'h00080;
   localparam logic [CpW-1:0] MinCp3     = 21'h00800;
   localparam logic [CpW-1:0] MinCp4     = 21'h10000;
   localparam logic [CpW-1:0] MaxCp      = 21'h10FFFF;
   localparam logic [CpW-1:0] SurrLo     = 21'h0D800;
   localparam logic [CpW-1:0] SurrHi     = 21'h0DFFF;
   localparam logic [CpW-1:0] BmpMax     = 21'h0FFFF;
   localparam logic [UnitW-1:0] HighBase = 16'hD800;
   localparam logic [UnitW-1:0] LowBase  = 16'hDC00;

   // sequence length minus one
   typedef enum logic [1:0] {
      SEQ_ONE   = 2'd0,
      SEQ_TWO   = 2'd1,
      SEQ_THREE = 2'd2,
      SEQ_FOUR  = 2'd3
   } seq_class_type;

   typedef struct packed {
      logic [1:0]     pending;
      logic [CpW-1:0] partial;
      seq_class_type  seq_class;
      logic           discard;
   } dec_state_type;

   typedef struct packed {
      logic [UnitW-1:0] code_unit;
      logic             error_flag;
      logic             last_of_string;
   } unit_type;

   typedef struct packed {
      logic [1:0] count;   // 0, 1 or 2 units
      unit_type   first;
      unit_type   second;
   } dec_out_type;

endpackage

`default_nettype wire

// ----- rtl/core/u8u16_if.sv -----
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for byte beats in and code unit beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_req_if;
   logic                      valid;
   logic                      ready;
   logic [u8u16_pkg::ByteW-1:0] data_byte;
   logic                      end_of_string;

   modport source (output valid, output data_byte, output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8u16_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [u8u16_pkg::UnitW-1:0] code_unit;
   logic                      error_flag;
   logic                      last_of_string;

   modport source (output valid, output code_unit, output error_flag,
                   output last_of_string, input ready);
   modport sink   (input valid, input code_unit, input error_flag,
                   input last_of_string, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/u8u16_decode.sv -----
// ----------------------------------------------------------------------------
// u8u16_decode
// One byte step of the UTF-8 state machine: next state and up to two units.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode (
   input  wire u8u16_pkg::dec_state_type        cur,
   input  wire logic [u8u16_pkg::ByteW-1:0]     data_byte,
   input  wire logic                            end_of_string,
   output u8u16_pkg::dec_state_type             nxt,
   output u8u16_pkg::dec_out_type               res
);

   u8u16_pkg::dec_state_type  clr;
   u8u16_pkg::unit_type       err_unit;
   logic [u8u16_pkg::CpW-1:0] cp;
   logic [u8u16_pkg::CpW-1:0] min_cp;
   logic [u8u16_pkg::CpW-1:0] ofs;
   logic                      cp_bad;

   always_comb begin
      clr           = '0;
      clr.seq_class = u8u16_pkg::SEQ_ONE;

      err_unit                = '0;
      err_unit.error_flag     = 1'b1;
      err_unit.last_of_string = 1'b1;

      cp = {cur.partial[u8u16_pkg::CpW-7:0], data_byte[5:0]};

      unique case (cur.seq_class)
         u8u16_pkg::SEQ_ONE:   min_cp = '0;
         u8u16_pkg::SEQ_TWO:   min_cp = u8u16_pkg::MinCp2;
         u8u16_pkg::SEQ_THREE: min_cp = u8u16_pkg::MinCp3;
         u8u16_pkg::SEQ_FOUR:  min_cp = u8u16_pkg::MinCp4;
         default:              min_cp = '0;
      endcase

      cp_bad = (cp < min_cp) || (cp > u8u16_pkg::MaxCp) ||
               ((cp >= u8u16_pkg::SurrLo) && (cp <= u8u16_pkg::SurrHi));
      ofs    = cp - u8u16_pkg::MinCp4;

      nxt   = cur;
      res   = '0;

      if (cur.discard) begin
         if (end_of_string) nxt = clr;
      end else if (cur.pending == 2'd0) begin
         priority if (!data_byte[7]) begin
            nxt                       = clr;
            res.count                 = 2'd1;
            res.first.code_unit       = {8'h00, data_byte};
            res.first.last_of_string  = end_of_string;
         end else if ((data_byte & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Match) begin
            nxt.partial   = {16'h0000, data_byte[4:0]};
            nxt.pending   = 2'd1;
            nxt.seq_class = u8u16_pkg::SEQ_TWO;
         end else if ((data_byte & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Match) begin
            nxt.partial   = {17'h00000, data_byte[3:0]};
            nxt.pending   = 2'd2;
            nxt.seq_class = u8u16_pkg::SEQ_THREE;
         end else if ((data_byte & u8u16_pkg::Lead4Mask) == u8u16_pkg::Lead4Match) begin
            nxt.partial   = {18'h00000, data_byte[2:0]};
            nxt.pending   = 2'd3;
            nxt.seq_class = u8u16_pkg::SEQ_FOUR;
         end else begin
            nxt         = clr;
            nxt.discard = !end_of_string;
            res.count   = 2'd1;
            res.first   = err_unit;
         end
         // a lead byte that ends the string is a truncated sequence
         if (data_byte[7] && end_of_string) begin
            nxt       = clr;
            res.count = 2'd1;
            res.first = err_unit;
         end
      end else if ((data_byte & u8u16_pkg::ContMask) != u8u16_pkg::ContMatch) begin
         nxt         = clr;
         nxt.discard = !end_of_string;
         res.count   = 2'd1;
         res.first   = err_unit;
      end else if (cur.pending != 2'd1) begin
         nxt.partial = cp;
         nxt.pending = cur.pending - 2'd1;
         if (end_of_string) begin
            nxt       = clr;
            res.count = 2'd1;
            res.first = err_unit;
         end
      end else if (cp_bad) begin
         nxt         = clr;
         nxt.discard = !end_of_string;
         res.count   = 2'd1;
         res.first   = err_unit;
      end else if (cp <= u8u16_pkg::BmpMax) begin
         nxt                      = clr;
         res.count                = 2'd1;
         res.first.code_unit      = cp[u8u16_pkg::UnitW-1:0];
         res.first.last_of_string = end_of_string;
      end else begin
         nxt                       = clr;
         res.count                 = 2'd2;
         res.first.code_unit       = u8u16_pkg::HighBase + {6'h00, ofs[19:10]};
         res.second.code_unit      = u8u16_pkg::LowBase + {6'h00, ofs[9:0]};
         res.second.last_of_string = end_of_string;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_to_utf16_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder, one byte beat in, one unit beat out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    handshake
//  req_if   in   data_byte[7:0], end_of_string              valid/ready
//  rsp_if   out  code_unit[15:0], error_flag, last_of_string valid/ready
//
//  A byte is registered, decoded from the input register once the queue has
//  room, and its 0..2 units land in a 4-entry result queue; one byte per
//  cycle sustained while the queue keeps two free entries, and a surrogate
//  pair leaves its units in turn (the single output port sets that limit).
//  Synchronous active-high reset clears decoder state, queue and input stage.
//  Decode waits while the queue has fewer than two free entries; the input
//  register keeps taking bytes while a finished unit waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder (
   input  wire logic     clock,
   input  wire logic     reset,
   u8u16_req_if.sink     req_if,
   u8u16_rsp_if.source   rsp_if
);

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic [u8u16_pkg::ByteW-1:0]   in_byte_ff,  in_byte_in;
   logic                          in_eos_ff,   in_eos_in;

   // decoder state
   u8u16_pkg::dec_state_type st_ff, st_in, st_nxt;
   u8u16_pkg::dec_out_type   dec_res;

   // result queue
   u8u16_pkg::unit_type            q_ff [u8u16_pkg::QDepth];
   u8u16_pkg::unit_type            q_in [u8u16_pkg::QDepth];
   logic [u8u16_pkg::QPtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [u8u16_pkg::QPtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [u8u16_pkg::QCntW-1:0]    cnt_ff,    cnt_in;
   logic [u8u16_pkg::QPtrW-1:0]    wr_ptr_p1;
   logic [1:0]                     push_cnt;

   logic fire;
   logic pop;
   logic req_beat;

   u8u16_decode u_decode (
      .cur           (st_ff),
      .data_byte     (in_byte_ff),
      .end_of_string (in_eos_ff),
      .nxt           (st_nxt),
      .res           (dec_res)
   );

   assign fire     = in_valid_ff &&
                     (cnt_ff <= u8u16_pkg::QCntW'(u8u16_pkg::QDepth - 2));
   assign pop      = rsp_if.valid && rsp_if.ready;
   assign req_beat = req_if.valid && req_if.ready;
   assign push_cnt = fire ? dec_res.count : 2'd0;
   assign wr_ptr_p1 = wr_ptr_ff + 1'b1;

   assign req_if.ready          = !in_valid_ff || fire;
   assign rsp_if.valid          = (cnt_ff != '0);
   assign rsp_if.code_unit      = q_ff[rd_ptr_ff].code_unit;
   assign rsp_if.error_flag     = q_ff[rd_ptr_ff].error_flag;
   assign rsp_if.last_of_string = q_ff[rd_ptr_ff].last_of_string;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eos_in   = in_eos_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.data_byte;
         in_eos_in   = req_if.end_of_string;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      st_in = fire ? st_nxt : st_ff;

      q_in = q_ff;
      if (push_cnt != 2'd0) q_in[wr_ptr_ff] = dec_res.first;
      if (push_cnt == 2'd2) q_in[wr_ptr_p1] = dec_res.second;

      wr_ptr_in = wr_ptr_ff + u8u16_pkg::QPtrW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + (pop ? 1'b1 : 1'b0);
      cnt_in    = cnt_ff + u8u16_pkg::QCntW'(push_cnt)
                         - u8u16_pkg::QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff       <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         st_ff       <= st_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eos_ff  <= in_eos_in;
      q_ff       <= q_in;
   end

   // queue never overfills
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= u8u16_pkg::QCntW'(u8u16_pkg::QDepth))
      else $error("result queue count out of range");

   // bytes swallowed after an error give nothing
   a_discard_silent: assert property (@(posedge clock) disable iff (reset)
      fire && st_ff.discard |-> push_cnt == 2'd0)
      else $error("unit produced while discarding");

   // the high half of a surrogate pair is never last nor an error
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      push_cnt == 2'd2 |-> !dec_res.first.last_of_string && !dec_res.first.error_flag)
      else $error("bad surrogate pair head");

   // an error beat always closes its string and carries no unit
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.error_flag |-> rsp_if.last_of_string && rsp_if.code_unit == '0)
      else $error("error beat not last or nonzero");

   // a decoded byte leaves the input register unless refilled
   a_in_drain: assert property (@(posedge clock) disable iff (reset)
      fire && !req_beat |=> !in_valid_ff)
      else $error("input register did not drain");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UTF-16 decoder. A table of directed
// byte beats is followed by random strings, mostly well formed, with faults
// mixed in. Each accepted byte runs through a bit-accurate decoder model, and
// unit beats are checked in order against the queue of predicted units.
// ----------------------------------------------------------------------------
module tb_top;
   import u8u16_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int ByteTarget = 750;

   typedef enum logic [1:0] {
      ROW_MODEL,   // take the units from the decoder model
      ROW_NONE,    // no unit
      ROW_ONE      // exactly the unit given in the row
   } row_kind_e;

   typedef struct {
      logic [7:0] b;
      logic       eos;
      row_kind_e  kind;
      unit_type   unit;
   } dir_row_t;

   localparam unit_type ErrUnit = '{16'h0000, 1'b1, 1'b1};

   logic clock;
   logic reset;

   u8u16_req_if req_bus ();
   u8u16_rsp_if rsp_bus ();

   utf8_to_utf16_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // decoder model state
   logic [1:0]    dec_pend;
   logic [CpW-1:0] dec_cp;
   seq_class_type dec_class;
   logic          dec_discard;

   unit_type expected_units[$];
   int       mismatches    = 0;
   int       decoded_bytes = 0;
   int       cycle_count   = 0;
   bit       gaps_on       = 1'b1;
   bit       hold_req      = 1'b0;

   dir_row_t dir_rows [25] = '{
      '{8'h00, 1'b0, ROW_ONE,   '{16'h0000, 1'b0, 1'b0}},
      '{8'h7F, 1'b1, ROW_ONE,   '{16'h007F, 1'b0, 1'b1}},
      '{8'hC2, 1'b0, ROW_MODEL, '0},
      '{8'h80, 1'b1, ROW_MODEL, '0},
      '{8'hEF, 1'b0, ROW_MODEL, '0},
      '{8'hBF, 1'b0, ROW_MODEL, '0},
      '{8'hBF, 1'b1, ROW_MODEL, '0},
      '{8'hF4, 1'b0, ROW_MODEL, '0},
      '{8'h8F, 1'b0, ROW_MODEL, '0},
      '{8'hBF, 1'b0, ROW_MODEL, '0},
      '{8'hBF, 1'b0, ROW_MODEL, '0},   // max code point, pair not last
      '{8'hC0, 1'b0, ROW_MODEL, '0},
      '{8'h80, 1'b1, ROW_ONE,   ErrUnit},   // overlong
      '{8'hED, 1'b0, ROW_MODEL, '0},
      '{8'hA0, 1'b0, ROW_MODEL, '0},
      '{8'h80, 1'b1, ROW_ONE,   ErrUnit},   // surrogate
      '{8'hF4, 1'b0, ROW_MODEL, '0},
      '{8'h90, 1'b0, ROW_MODEL, '0},
      '{8'h80, 1'b0, ROW_MODEL, '0},
      '{8'h80, 1'b1, ROW_ONE,   ErrUnit},   // above 10FFFF
      '{8'hFF, 1'b0, ROW_ONE,   ErrUnit},   // bad lead, rest swallowed
      '{8'hE2, 1'b1, ROW_NONE,  '0},
      '{8'hC3, 1'b1, ROW_ONE,   ErrUnit},   // string ends mid-sequence
      '{8'hE2, 1'b0, ROW_MODEL, '0},
      '{8'h41, 1'b1, ROW_ONE,   ErrUnit}    // bad continuation
   };

   function automatic void drop_sequence();
      dec_pend  = 2'd0;
      dec_cp    = '0;
      dec_class = SEQ_ONE;
   endfunction

   // Returns the number of units the byte produces (0..2).
   function automatic int decode_byte(input logic [7:0] b, input logic eos,
                                      output unit_type unit_a, output unit_type unit_b);
      logic [CpW-1:0] min_cp;
      logic [CpW-1:0] offs;
      logic           fault;
      int             n;
      unit_a = '0;
      unit_b = '0;
      fault  = 1'b0;
      n      = 0;
      if (dec_discard) begin
         if (eos) begin
            dec_discard = 1'b0;
            drop_sequence();
         end
      end else if (dec_pend == 2'd0) begin
         if (!b[7]) begin
            drop_sequence();
            unit_a = '{{8'h00, b}, 1'b0, eos};
            n = 1;
         end else begin
            if ((b & Lead2Mask) == Lead2Match) begin
               dec_cp = CpW'(b[4:0]);
               dec_pend = 2'd1;
               dec_class = SEQ_TWO;
            end else if ((b & Lead3Mask) == Lead3Match) begin
               dec_cp = CpW'(b[3:0]);
               dec_pend = 2'd2;
               dec_class = SEQ_THREE;
            end else if ((b & Lead4Mask) == Lead4Match) begin
               dec_cp = CpW'(b[2:0]);
               dec_pend = 2'd3;
               dec_class = SEQ_FOUR;
            end else begin
               fault = 1'b1;
            end
            if (eos) fault = 1'b1;
         end
      end else if ((b & ContMask) != ContMatch) begin
         fault = 1'b1;
      end else begin
         dec_cp = {dec_cp[CpW-7:0], b[5:0]};
         dec_pend = dec_pend - 2'd1;
         if (dec_pend != 2'd0) begin
            if (eos) fault = 1'b1;
         end else begin
            case (dec_class)
               SEQ_TWO:   min_cp = MinCp2;
               SEQ_THREE: min_cp = MinCp3;
               SEQ_FOUR:  min_cp = MinCp4;
               default:   min_cp = '0;
            endcase
            if (dec_cp < min_cp || dec_cp > MaxCp || (dec_cp >= SurrLo && dec_cp <= SurrHi)) begin
               fault = 1'b1;
            end else if (dec_cp <= BmpMax) begin
               unit_a = '{dec_cp[15:0], 1'b0, eos};
               n = 1;
               drop_sequence();
            end else begin
               offs = dec_cp - MinCp4;
               unit_a = '{HighBase + 16'(offs[19:10]), 1'b0, 1'b0};
               unit_b = '{LowBase + 16'(offs[9:0]), 1'b0, eos};
               n = 2;
               drop_sequence();
            end
         end
      end
      if (fault) begin
         drop_sequence();
         dec_discard = !eos;
         unit_a = ErrUnit;
         n = 1;
      end
      return n;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eos,
                            input row_kind_e kind, input unit_type typed);
      unit_type unit_a;
      unit_type unit_b;
      int       n;
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < 15) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.end_of_string <= eos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!dec_discard) decoded_bytes++;
      n = decode_byte(b, eos, unit_a, unit_b);
      if (kind == ROW_MODEL) begin
         if (n > 0) expected_units.insert(expected_units.size(), unit_a);
         if (n > 1) expected_units.insert(expected_units.size(), unit_b);
      end else if (kind == ROW_ONE) begin
         expected_units.insert(expected_units.size(), typed);
      end
   endtask

   function automatic int utf8_len(input logic [CpW-1:0] cp);
      if (cp < MinCp2) return 1;
      if (cp < MinCp3) return 2;
      if (cp < MinCp4) return 3;
      return 4;
   endfunction

   // nbytes may exceed the natural length to build overlong forms
   task automatic append_cp(ref logic [7:0] str[$], input logic [CpW-1:0] cp,
                            input int nbytes);
      case (nbytes)
         1: str.insert(str.size(), {1'b0, cp[6:0]});
         2: begin
            str.insert(str.size(), {3'b110, cp[10:6]});
            str.insert(str.size(), {2'b10, cp[5:0]});
         end
         3: begin
            str.insert(str.size(), {4'b1110, cp[15:12]});
            str.insert(str.size(), {2'b10, cp[11:6]});
            str.insert(str.size(), {2'b10, cp[5:0]});
         end
         default: begin
            str.insert(str.size(), {5'b11110, cp[20:18]});
            str.insert(str.size(), {2'b10, cp[17:12]});
            str.insert(str.size(), {2'b10, cp[11:6]});
            str.insert(str.size(), {2'b10, cp[5:0]});
         end
      endcase
   endtask

   function automatic logic [CpW-1:0] pick_code_point();
      logic [CpW-1:0] edges [10] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                                     21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};
      logic [CpW-1:0] cp;
      case ($urandom_range(0, 9))
         0, 1, 2: cp = CpW'($urandom_range(0, 'h7F));
         3, 4:    cp = CpW'($urandom_range('h80, 'h7FF));
         5, 6: begin
            cp = CpW'($urandom_range('h800, 'hFFFF));
            if (cp >= SurrLo && cp <= SurrHi) cp = cp ^ 21'h2000;
         end
         7, 8:    cp = CpW'($urandom_range('h10000, 'h10FFFF));
         default: cp = edges[$urandom_range(0, 9)];
      endcase
      return cp;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // result side: random back-pressure plus one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (80) @(negedge clock);
         end
         rsp_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 15);
      end
   end

   always @(posedge clock) begin : check_units
      unit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_units.size() == 0) begin
            $error("unit beat with none pending: code_unit=%h error_flag=%b last_of_string=%b",
                   rsp_bus.code_unit, rsp_bus.error_flag, rsp_bus.last_of_string);
            mismatches++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_bus.code_unit !== want.code_unit) begin
               $error("code_unit: expected %h, got %h", want.code_unit, rsp_bus.code_unit);
               mismatches++;
            end
            if (rsp_bus.error_flag !== want.error_flag) begin
               $error("error_flag: expected %b, got %b", want.error_flag, rsp_bus.error_flag);
               mismatches++;
            end
            if (rsp_bus.last_of_string !== want.last_of_string) begin
               $error("last_of_string: expected %b, got %b",
                      want.last_of_string, rsp_bus.last_of_string);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [7:0]     str[$];
      logic [CpW-1:0] cp;
      int             nb;
      int             idx;
      int             strings;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = 8'h00;
      req_bus.end_of_string = 1'b0;
      dec_discard           = 1'b0;
      drop_sequence();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].kind, dir_rows[i].unit);

      strings = 0;
      while (decoded_bytes < ByteTarget) begin
         strings++;
         if (strings == 20) hold_req = 1'b1;
         gaps_on = !(decoded_bytes >= 300 && decoded_bytes < 450);
         str.delete();
         repeat ($urandom_range(1, 4)) begin
            cp = pick_code_point();
            append_cp(str, cp, utf8_len(cp));
         end
         if ($urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 5))
               0: begin
                  str.delete();
                  repeat ($urandom_range(1, 5))
                     str.insert(str.size(), 8'($urandom_range(0, 255)));
               end
               1: begin
                  nb = $urandom_range(2, 4);
                  cp = CpW'($urandom_range(0, nb == 2 ? 'h7F : nb == 3 ? 'h7FF : 'hFFFF));
                  append_cp(str, cp, nb);
               end
               2: append_cp(str, CpW'($urandom_range('hD800, 'hDFFF)), 3);
               3: append_cp(str, CpW'($urandom_range('h110000, 'h1FFFFF)), 4);
               4: begin
                  nb = $urandom_range(2, 4);
                  cp = CpW'($urandom_range(nb == 2 ? 'h80 : nb == 3 ? 'h800 : 'h10000,
                                           nb == 2 ? 'h7FF : nb == 3 ? 'hD7FF : 'h10FFFF));
                  append_cp(str, cp, nb);
                  repeat ($urandom_range(1, nb - 1)) void'(str.pop_back());
               end
               default: begin
                  // a random byte gets top bits other than 10
                  idx = $urandom_range(0, str.size() - 1);
                  str[idx] = {2'($urandom_range(1, 3)) ^ 2'b10, 6'($urandom_range(0, 63))};
               end
            endcase
            if ($urandom_range(0, 1) == 1) begin
               cp = pick_code_point();
               append_cp(str, cp, utf8_len(cp));
            end
         end
         foreach (str[i])
            send_byte(str[i], i == str.size() - 1, ROW_MODEL, '0);
      end
      gaps_on = 1'b1;

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
